[rtl/assert_macros.svh]
// Assertion helper macros for the SHA-1 digest block.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHA1D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SHA1D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sha1d_pkg.sv]
// Shared types, constants and round functions for the SHA-1 digest block.
// No dependencies.
package sha1d_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [7:0] ADDR_CLEAR    = 8'hFE;
  localparam logic [7:0] ADDR_SET      = 8'h02;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [5:0] FILL_FULL  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [2:0] OUT_LAST   = 3'd4;

  localparam logic MODE_DIGEST  = 1'b0;
  localparam logic MODE_ADDRESS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic pad_mark;
    logic pad_zero;
    logic pad_len;
    logic round;
    logic add;
    logic out_load;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       out_free;
    logic       out_final;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    priority if (r < 7'd20) begin
      round_f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    priority if (r < 7'd20) begin
      round_k = K_R0;
    end else if (r < 7'd40) begin
      round_k = K_R1;
    end else if (r < 7'd60) begin
      round_k = K_R2;
    end else begin
      round_k = K_R3;
    end
  endfunction

endpackage

[rtl/sha1d_ctrl.sv]
// Sequencer for the SHA-1 digest block: byte intake, padding, rounds, output.
// Depends on sha1d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1d_ctrl import sha1d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    no_data,
  input  logic    last_byte,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic finishing, finishing_next;
  logic marked, marked_next;
  logic final_blk, final_blk_next;
  logic accept;
  logic has_byte;

  assign accept   = in_valid && (state == ST_IDLE);
  assign has_byte = !no_data;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      marked    <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      marked    <= marked_next;
      final_blk <= final_blk_next;
    end
  end

  // next state and sequencing flags
  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    marked_next    = marked;
    final_blk_next = final_blk;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          finishing_next = last_byte;
          priority if (has_byte && status.fill == FILL_FULL) begin
            state_next = ST_ROUND;
          end else if (last_byte) begin
            state_next = ST_PAD_MARK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ROUND: begin
        if (status.round_last) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        priority if (final_blk) begin
          state_next = ST_OUT;
        end else if (finishing && !marked) begin
          state_next = ST_PAD_MARK;
        end else if (finishing) begin
          state_next = ST_PAD_ZERO;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD_MARK: begin
        marked_next = 1'b1;
        state_next  = (status.fill == FILL_FULL) ? ST_ROUND : ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        priority if (status.fill == FILL_LEN) begin
          final_blk_next = 1'b1;
          state_next     = ST_ROUND;
        end else if (status.fill == FILL_FULL) begin
          state_next = ST_ROUND;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_OUT: begin
        if (status.out_free && status.out_final) begin
          state_next     = ST_IDLE;
          finishing_next = 1'b0;
          marked_next    = 1'b0;
          final_blk_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_byte = accept && has_byte;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
      end
      ST_PAD_MARK: begin
        cmd.pad_mark = 1'b1;
      end
      ST_PAD_ZERO: begin
        cmd.pad_len  = (status.fill == FILL_LEN);
        cmd.pad_zero = (status.fill != FILL_LEN);
      end
      ST_OUT: begin
        cmd.out_load = status.out_free;
        cmd.restart  = status.out_free && status.out_final;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `SHA1D_ASSERT_NEXT(a_round_to_add, clk, rst, state == ST_ROUND && status.round_last, state == ST_ADD)

endmodule

[rtl/sha1d_datapath.sv]
// Datapath of the SHA-1 digest block: message window, round unit, chaining
// words, counters and output register. Depends on sha1d_pkg, assert_macros.svh.
`include "assert_macros.svh"

module sha1d_datapath import sha1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  data_byte,
  input  logic        cfg_write,
  input  logic        cfg_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] result_value,
  output logic        result_last
);

  logic [511:0] msg, msg_next;
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [6:0]   round_idx;
  logic [2:0]   out_idx;
  logic         mode;
  logic [31:0]  chain [5];
  logic [31:0]  work  [5];
  logic [31:0]  chain_sum [5];
  logic [31:0]  w_new;
  logic [31:0]  t_sum;
  logic [7:0]   shift_byte;
  logic [47:0]  addr;
  logic         out_free;
  logic         out_final;

  assign out_free  = !out_valid || out_ready;
  assign out_final = (mode == MODE_ADDRESS) || (out_idx == OUT_LAST);

  assign status.fill       = fill;
  assign status.round_last = (round_idx == ROUND_LAST);
  assign status.out_free   = out_free;
  assign status.out_final  = out_final;

  // window holds W[t..t+15], word 0 in the top bits
  assign w_new = rotl32(msg[95:64] ^ msg[255:224] ^ msg[447:416] ^ msg[511:480], 1);
  assign t_sum = rotl32(work[0], 5) + round_f(round_idx, work[1], work[2], work[3])
               + work[4] + round_k(round_idx) + msg[511:480];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      chain_sum[i] = chain[i] + work[i];
    end
  end

  always_comb begin
    priority if (cmd.load_byte) begin
      shift_byte = data_byte;
    end else if (cmd.pad_mark) begin
      shift_byte = PAD_MARK_BYTE;
    end else begin
      shift_byte = 8'h00;
    end
  end

  always_comb begin
    priority if (cmd.round) begin
      msg_next = {msg[479:0], w_new};
    end else if (cmd.pad_len) begin
      msg_next = {msg[447:0], bit_count};
    end else if (cmd.load_byte || cmd.pad_mark || cmd.pad_zero) begin
      msg_next = {msg[503:0], shift_byte};
    end else begin
      msg_next = msg;
    end
  end

  assign addr = {((chain[0][31:24] & ADDR_CLEAR) | ADDR_SET), chain[0][23:0],
                 chain[1][31:16]};

  always_ff @(posedge clk) begin
    msg <= msg_next;
    if (cmd.out_load) begin
      result_value <= (mode == MODE_ADDRESS) ? addr : {16'h0000, chain[out_idx]};
      result_last  <= out_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain[0]  <= H0_INIT;
      chain[1]  <= H1_INIT;
      chain[2]  <= H2_INIT;
      chain[3]  <= H3_INIT;
      chain[4]  <= H4_INIT;
      work[0]   <= H0_INIT;
      work[1]   <= H1_INIT;
      work[2]   <= H2_INIT;
      work[3]   <= H3_INIT;
      work[4]   <= H4_INIT;
      fill      <= '0;
      bit_count <= '0;
      round_idx <= '0;
    end else begin
      if (cmd.load_byte || cmd.pad_mark || cmd.pad_zero) begin
        fill <= fill + 6'd1;
      end else if (cmd.pad_len) begin
        fill <= '0;
      end
      if (cmd.load_byte) begin
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.round) begin
        round_idx <= status.round_last ? 7'd0 : round_idx + 7'd1;
        work[0]   <= t_sum;
        work[1]   <= work[0];
        work[2]   <= rotl32(work[1], 30);
        work[3]   <= work[2];
        work[4]   <= work[3];
      end
      if (cmd.add) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain_sum[i];
          work[i]  <= chain_sum[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_DIGEST;
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_mode;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_idx   <= out_final ? 3'd0 : out_idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SHA1D_ASSERT_NEXT(a_round_wrap, clk, rst, cmd.round && round_idx == ROUND_LAST, round_idx == 7'd0)
  `SHA1D_ASSERT_NEXT(a_last_flag, clk, rst, cmd.out_load && out_final, out_valid && result_last)
  `SHA1D_ASSERT_IMP(a_round_full_block, clk, rst, cmd.round, fill == 6'd0)

endmodule

[rtl/sha1_hash_mac_derive.sv]
// Top level of the streaming SHA-1 digest / address derivation block.
// Depends on sha1d_pkg, sha1d_ctrl and sha1d_datapath.
//
// Input channel (in_valid/in_ready): one word per message byte, data_byte,
// or an end marker with no_data set; last_byte ends the message.
// Output channel (out_valid/out_ready): output_mode 0 gives five digest
// words H0..H4 in result_value[31:0]; mode 1 gives one 48-bit locally
// administered unicast address. result_last flags the final word.
// Config channel (cfg_valid/cfg_ready, output_mode): always ready; write it
// only while the block is idle.
// Timing: bytes enter one per cycle while idle; the 64th byte of a block
// starts a compression (80 rounds on the single round unit plus the
// chaining add). On the last word, padding shifts in one byte per cycle
// (held while a block compresses) and the 8-byte length at once; one or
// two more compressions run; results then leave one per cycle while accepted.
// A stalled receiver holds the output register and the block waits before
// emitting; after the final word is loaded a new message may start.
// Reset (rst, synchronous) restores the initial chaining values, clears the
// byte and bit counters and sets output_mode to 0.
module sha1_hash_mac_derive import sha1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        no_data,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] result_value,
  output logic        result_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        output_mode
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sha1d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .no_data   (no_data),
    .last_byte (last_byte),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sha1d_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (data_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_mode     (output_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_last  (result_last)
  );

endmodule
